/* hw/rtl/rar_pkg.sv */
// Shared types and constants for the rational arithmetic reduce unit.
// Used by the top level, the reduction engine and the port checker; depends on nothing.
package rar_pkg;

  localparam int OPCODE_W  = 2;
  localparam int NUM_OUT_W = 33;
  localparam int DEN_OUT_W = 32;
  localparam int M_TDATA_W = ((NUM_OUT_W + DEN_OUT_W + 7) / 8) * 8;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_ZERO_DEN = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_N1,
    ST_MUL_D,
    ST_MUL_N2,
    ST_SUM,
    ST_REDUCE,
    ST_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    RED_IDLE,
    RED_GCD,
    RED_DIVN,
    RED_DIVD
  } red_state_t;

endpackage

/* hw/rtl/rar_reduce.sv */
// Reduction engine: binary gcd of two magnitudes, then two exact divisions by it.
// One shared subtractor serves both phases. Depends on rar_pkg.
module rar_reduce #(
  parameter int NW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num_in,
  input  logic [NW-1:0] den_in,
  output logic          done,
  output logic [NW-1:0] num_out,
  output logic [NW-1:0] den_out
);

  localparam int KW = $clog2(NW);

  rar_pkg::red_state_t state, state_next;

  logic [NW-1:0] gx, gy, divisor, rem, quo, num_q, den_q;
  logic [KW-1:0] gk, cnt;

  logic          x_lt_y;
  logic [NW:0]   rem_sh, sub_a;
  logic [NW-1:0] sub_b, rem_new, quo_next;
  logic [NW+1:0] diff;
  logic          borrow, last;

  always_comb begin
    x_lt_y = gx < gy;
    rem_sh = {rem, quo[NW-1]};
    if (state == rar_pkg::RED_GCD) begin
      sub_a = {1'b0, (x_lt_y ? gy : gx)};
      sub_b = x_lt_y ? gx : gy;
    end else begin
      sub_a = rem_sh;
      sub_b = divisor;
    end
    diff     = {1'b0, sub_a} - {2'b00, sub_b};
    borrow   = diff[NW+1];
    rem_new  = borrow ? rem_sh[NW-1:0] : diff[NW-1:0];
    quo_next = {quo[NW-2:0], ~borrow};
    last     = (cnt == KW'(NW - 1));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rar_pkg::RED_IDLE: if (start) state_next = rar_pkg::RED_GCD;
      rar_pkg::RED_GCD:  if (gx == gy) state_next = rar_pkg::RED_DIVN;
      rar_pkg::RED_DIVN: if (last) state_next = rar_pkg::RED_DIVD;
      rar_pkg::RED_DIVD: if (last) state_next = rar_pkg::RED_IDLE;
      default:           state_next = rar_pkg::RED_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rar_pkg::RED_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == rar_pkg::RED_DIVD) && last;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rar_pkg::RED_IDLE: begin
        if (start) begin
          num_q <= num_in;
          den_q <= den_in;
          gx    <= num_in;
          gy    <= den_in;
          gk    <= '0;
        end
      end
      rar_pkg::RED_GCD: begin
        if (gx == gy) begin
          divisor <= gx << gk;
          rem     <= '0;
          quo     <= num_q;
          cnt     <= '0;
        end else if (!gx[0] && !gy[0]) begin
          gx <= gx >> 1;
          gy <= gy >> 1;
          gk <= gk + 1'b1;
        end else if (!gx[0]) begin
          gx <= gx >> 1;
        end else if (!gy[0]) begin
          gy <= gy >> 1;
        end else if (x_lt_y) begin
          gy <= diff[NW:1];
        end else begin
          gx <= diff[NW:1];
        end
      end
      rar_pkg::RED_DIVN: begin
        if (last) begin
          num_q <= quo_next;
          quo   <= den_q;
          rem   <= '0;
          cnt   <= '0;
        end else begin
          quo <= quo_next;
          rem <= rem_new;
          cnt <= cnt + 1'b1;
        end
      end
      rar_pkg::RED_DIVD: begin
        if (last) begin
          den_q <= quo_next;
        end else begin
          quo <= quo_next;
          rem <= rem_new;
          cnt <= cnt + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign num_out = num_q;
  assign den_out = den_q;

endmodule

/* hw/rtl/rational_arith_reduce_unit.sv */
// Sequence: the products (the right numerator term only for add and subtract), then the
// zero checks; a zero denominator or numerator goes straight to the output register,
// otherwise the binary gcd loop and two bit-serial divisions over NW = 2*VALUE_WIDTH run first.
// Items are handled one at a time; the next item is taken only after the result has entered
// the output register, so the gcd loop and the two bit-serial divisions set the rate.
// Reset: synchronous, active high; clears the sequencer, the engine and the output valid.
module rational_arith_reduce_unit #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  // s_tdata fields from bit 0 up: opcode, a_num, a_den, b_num, b_den, zero fill to bytes.
  input  logic [((rar_pkg::OPCODE_W + 4*VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic s_tvalid,
  output logic s_tready,
  // m_tdata fields from bit 0 up: res_num (33 bits), res_den (32 bits), zero fill.
  output logic [rar_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser fields: status (1 = zero result denominator).
  output logic m_tuser,
  output logic m_tvalid,
  input  logic m_tready
);

  localparam int W  = VALUE_WIDTH;
  localparam int NW = 2 * VALUE_WIDTH;
  // Wide enough to negate a magnitude and still cut out the 33-bit result field.
  localparam int XW = (NW > rar_pkg::NUM_OUT_W) ? NW : rar_pkg::NUM_OUT_W;
  localparam int PAD_W = rar_pkg::M_TDATA_W - rar_pkg::NUM_OUT_W - rar_pkg::DEN_OUT_W;

  rar_pkg::top_state_t state, state_next;
  rar_pkg::opcode_t    op, in_op;

  // Operands are held in sign and magnitude form; the magnitude of the most
  // negative value needs the full W bits.
  logic          an_neg, ad_neg, bn_neg, bd_neg;
  logic [W-1:0]  an_mag, ad_mag, bn_mag, bd_mag;
  logic [W-1:0]  in_an, in_ad, in_bn, in_bd;

  // Single shared multiplier, its product registered in one of three places.
  logic [W-1:0]  mul_a, mul_b;
  logic [NW-1:0] mul_p;
  logic [NW-1:0] p_n1, p_n2, p_d;
  logic          n1_neg, n2_neg, d_neg;

  logic [NW-1:0] sum_mag;
  logic          sum_neg;

  // Result held until the output register is free.
  logic [NW-1:0] num_mag, den_mag;
  logic          num_neg, den_neg, err;

  logic          red_start, red_done;
  logic [NW-1:0] red_num, red_den;

  logic          accept, out_load;
  logic [XW-1:0] num_ext, den_ext, num_s, den_s;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == rar_pkg::ST_IDLE);
  assign out_load = (state == rar_pkg::ST_OUT) && (!m_tvalid || m_tready);

  // Unpack the input item; each fraction part is turned into a magnitude when it is captured.
  always_comb begin
    in_op = rar_pkg::opcode_t'(s_tdata[rar_pkg::OPCODE_W-1:0]);
    in_an = s_tdata[rar_pkg::OPCODE_W         +: W];
    in_ad = s_tdata[rar_pkg::OPCODE_W + W     +: W];
    in_bn = s_tdata[rar_pkg::OPCODE_W + 2*W   +: W];
    in_bd = s_tdata[rar_pkg::OPCODE_W + 3*W   +: W];
  end

  // Operand selection for the multiplier. The first product is the left
  // numerator term, the second the denominator, the third the right
  // numerator term, which only add and subtract need.
  always_comb begin
    mul_a = bn_mag;
    mul_b = ad_mag;
    unique case (state)
      rar_pkg::ST_MUL_N1: begin
        mul_a = an_mag;
        mul_b = (op == rar_pkg::OP_MUL) ? bn_mag : bd_mag;
      end
      rar_pkg::ST_MUL_D: begin
        mul_a = ad_mag;
        mul_b = (op == rar_pkg::OP_DIV) ? bn_mag : bd_mag;
      end
      default: begin
        mul_a = bn_mag;
        mul_b = ad_mag;
      end
    endcase
    mul_p = NW'(mul_a) * NW'(mul_b);
  end

  // Sign and magnitude sum of the two numerator terms. For multiply and
  // divide the numerator is the first term alone.
  always_comb begin
    if (op == rar_pkg::OP_MUL || op == rar_pkg::OP_DIV) begin
      sum_mag = p_n1;
      sum_neg = n1_neg;
    end else if (n1_neg == n2_neg) begin
      sum_mag = p_n1 + p_n2;
      sum_neg = n1_neg;
    end else if (p_n1 >= p_n2) begin
      sum_mag = p_n1 - p_n2;
      sum_neg = n1_neg;
    end else begin
      sum_mag = p_n2 - p_n1;
      sum_neg = n2_neg;
    end
  end

  // Sequencer: next state and the start pulse for the reduction engine.
  always_comb begin
    state_next = state;
    red_start  = 1'b0;
    unique case (state)
      rar_pkg::ST_IDLE:   if (accept) state_next = rar_pkg::ST_MUL_N1;
      rar_pkg::ST_MUL_N1: state_next = rar_pkg::ST_MUL_D;
      rar_pkg::ST_MUL_D: begin
        if (op == rar_pkg::OP_ADD || op == rar_pkg::OP_SUB) begin
          state_next = rar_pkg::ST_MUL_N2;
        end else begin
          state_next = rar_pkg::ST_SUM;
        end
      end
      rar_pkg::ST_MUL_N2: state_next = rar_pkg::ST_SUM;
      rar_pkg::ST_SUM: begin
        // A zero denominator is checked before a zero numerator.
        if (p_d == '0 || sum_mag == '0) begin
          state_next = rar_pkg::ST_OUT;
        end else begin
          red_start  = 1'b1;
          state_next = rar_pkg::ST_REDUCE;
        end
      end
      rar_pkg::ST_REDUCE: if (red_done) state_next = rar_pkg::ST_OUT;
      rar_pkg::ST_OUT:    if (out_load) state_next = rar_pkg::ST_IDLE;
      default:            state_next = rar_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rar_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Operand capture, products and the result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      rar_pkg::ST_IDLE: begin
        if (accept) begin
          op     <= in_op;
          an_neg <= in_an[W-1];
          ad_neg <= in_ad[W-1];
          bn_neg <= in_bn[W-1];
          bd_neg <= in_bd[W-1];
          an_mag <= in_an[W-1] ? W'(-in_an) : in_an;
          ad_mag <= in_ad[W-1] ? W'(-in_ad) : in_ad;
          bn_mag <= in_bn[W-1] ? W'(-in_bn) : in_bn;
          bd_mag <= in_bd[W-1] ? W'(-in_bd) : in_bd;
        end
      end
      rar_pkg::ST_MUL_N1: begin
        p_n1   <= mul_p;
        n1_neg <= an_neg ^ ((op == rar_pkg::OP_MUL) ? bn_neg : bd_neg);
      end
      rar_pkg::ST_MUL_D: begin
        p_d   <= mul_p;
        d_neg <= ad_neg ^ ((op == rar_pkg::OP_DIV) ? bn_neg : bd_neg);
      end
      rar_pkg::ST_MUL_N2: begin
        p_n2   <= mul_p;
        n2_neg <= bn_neg ^ ad_neg ^ (op == rar_pkg::OP_SUB);
      end
      rar_pkg::ST_SUM: begin
        if (p_d == '0) begin
          num_mag <= '0;
          den_mag <= '0;
          num_neg <= 1'b0;
          den_neg <= 1'b0;
          err     <= rar_pkg::STATUS_ZERO_DEN;
        end else if (sum_mag == '0) begin
          num_mag <= '0;
          den_mag <= NW'(1);
          num_neg <= 1'b0;
          den_neg <= 1'b0;
          err     <= rar_pkg::STATUS_OK;
        end else begin
          num_neg <= sum_neg;
          den_neg <= d_neg;
          err     <= rar_pkg::STATUS_OK;
        end
      end
      rar_pkg::ST_REDUCE: begin
        if (red_done) begin
          num_mag <= red_num;
          den_mag <= red_den;
        end
      end
      default: ;
    endcase
  end

  rar_reduce #(
    .NW(NW)
  ) u_reduce (
    .clk     (clk),
    .rst     (rst),
    .start   (red_start),
    .num_in  (sum_mag),
    .den_in  (p_d),
    .done    (red_done),
    .num_out (red_num),
    .den_out (red_den)
  );

  // Back to two's complement, wrapped to the result field widths.
  always_comb begin
    num_ext = XW'(num_mag);
    den_ext = XW'(den_mag);
    num_s   = num_neg ? -num_ext : num_ext;
    den_s   = den_neg ? -den_ext : den_ext;
  end

  // Output register: holds a finished item until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{PAD_W{1'b0}}, den_s[rar_pkg::DEN_OUT_W-1:0],
                  num_s[rar_pkg::NUM_OUT_W-1:0]};
      m_tuser <= err;
    end
  end

endmodule

/* hw/rtl/rar_checker.sv */
// Port-level checker for the rational arithmetic reduce unit, bound to the top level.
// Depends on rar_pkg for the result field layout.
module rar_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [rar_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready
);

  localparam int NO = rar_pkg::NUM_OUT_W;
  localparam int DO = rar_pkg::DEN_OUT_W;

  // A held result must not change while it waits.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // The unit works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == rar_pkg::STATUS_ZERO_DEN) |-> m_tdata == '0)
    else $error("error result carries nonzero fields");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == rar_pkg::STATUS_OK) |-> m_tdata[NO +: DO] != '0)
    else $error("valid result with zero denominator");

  a_zero_num_one: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == rar_pkg::STATUS_OK) && (m_tdata[NO-1:0] == '0)
    |-> m_tdata[NO +: DO] == DO'(1))
    else $error("zero numerator not reduced to 0/1");

endmodule

bind rational_arith_reduce_unit rar_checker u_rar_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
